/* rtl/core/cursor_sequence_store_unit_defines.svh */
// Assertion macros used by the cursor sequence store checker.
`ifndef CURSOR_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define CURSOR_SEQUENCE_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CSSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor sequence store: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CSSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor sequence store: assertion failed");

`endif

/* rtl/core/csstore_pkg.sv */
// Types and codes of the cursor sequence store.
package csstore_pkg;

    localparam int OP_BITS     = 3;
    localparam int IN_WORD     = 32;
    localparam int OUT_WORD    = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_OUT   = 6;
    localparam int POS_BITS    = 11;
    localparam int MAX_WORD    = 64;

    typedef enum logic [OP_BITS-1:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCUR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [POS_BITS-1:0]   pos;
        logic [MAX_WORD-1:0]   word;
    } cmd_t;

endpackage

/* rtl/core/csstore_if.sv */
// Request and response channel interfaces of the cursor sequence store.
interface csstore_req_if;
    logic                             valid;
    logic                             ready;
    logic [csstore_pkg::OP_BITS-1:0]  operation;
    logic [csstore_pkg::IN_WORD-1:0]  entry_value;

    modport source (output valid, output operation, output entry_value, input ready);
    modport sink   (input valid, input operation, input entry_value, output ready);
endinterface

interface csstore_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [csstore_pkg::STATUS_BITS-1:0]  status;
    logic                                 has_current;
    logic [csstore_pkg::OUT_WORD-1:0]     current_value;
    logic [csstore_pkg::COUNT_OUT-1:0]    item_count;

    modport source (output valid, output status, output has_current,
                    output current_value, output item_count, input ready);
    modport sink   (input valid, input status, input has_current,
                    input current_value, input item_count, output ready);
endinterface

/* rtl/core/csstore_cell.sv */
// One storage cell of the entry chain, shifting with its neighbours.
module csstore_cell #(
    parameter int WORD_BITS = 32,
    parameter int CNT_BITS  = 6,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  csstore_pkg::cmd_t     cmd,
    input  logic [WORD_BITS-1:0]  left_word,
    input  logic [WORD_BITS-1:0]  right_word,
    input  logic [CNT_BITS-1:0]   cursor,
    output logic [WORD_BITS-1:0]  word,
    output logic [WORD_BITS-1:0]  sel_word
);
    import csstore_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 at_pos;
    logic                 above_pos;

    assign at_pos    = (cmd.pos == POS_BITS'(INDEX));
    assign above_pos = (cmd.pos < POS_BITS'(INDEX));

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.kind)
            CMD_OPEN:
            begin
                if (at_pos)
                begin
                    word_next = cmd.word[WORD_BITS-1:0];
                end
                else if (above_pos)
                begin
                    word_next = left_word;
                end
            end
            CMD_CLOSE:
            begin
                if (at_pos || above_pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = (cursor == CNT_BITS'(INDEX)) ? word_reg : '0;
endmodule

/* rtl/core/cursor_sequence_store_unit.sv */
// Cursor sequence store: a chain of word cells with a cursor and entry count.
// A request is taken only in the idle state: on acceptance the cell chain shifts and the
// store enters its result state, from which the cell under the cursor is read into the
// response register; only then is a new request taken. A result beat left waiting
// holds the store in its result state and stalls further requests.
// Reset (rst_n, asynchronous, active low) empties the store and parks the cursor at
// zero; the cell words themselves are not cleared and are unreadable until written.
module cursor_sequence_store_unit #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    csstore_req_if.sink   req,
    csstore_rsp_if.source rsp
);
    import csstore_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [CNT_BITS-1:0]   cursor_reg;
    logic [CNT_BITS-1:0]   cursor_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic                  out_has_reg;
    logic [OUT_WORD-1:0]   out_value_reg;
    logic [COUNT_OUT-1:0]  out_count_reg;

    cmd_t                  cmd;
    logic                  accept;
    logic                  cur_valid;
    logic                  full;
    logic [CNT_BITS-1:0]   at;
    logic                  load_out;
    logic [WORD_BITS-1:0]  chain_word [DEPTH];
    logic [WORD_BITS-1:0]  chain_sel  [DEPTH];
    logic [WORD_BITS-1:0]  sel_or;
    logic [MAX_WORD-1:0]   sel_wide;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cur_valid = (cursor_reg < count_reg);
    assign full      = (count_reg == CNT_BITS'(DEPTH));

    always_comb
    begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        status_next = status_reg;
        cmd.kind    = CMD_HOLD;
        cmd.pos     = '0;
        cmd.word    = MAX_WORD'(req.entry_value);
        at          = '0;
        if (accept)
        begin
            status_next = ST_DONE;
            unique case (req.operation)
                OP_START:
                begin
                    cursor_next = '0;
                end
                OP_ADVANCE:
                begin
                    if (cur_valid)
                    begin
                        cursor_next = CNT_BITS'(cursor_reg + 1'b1);
                    end
                    else
                    begin
                        status_next = ST_NOCUR;
                    end
                end
                OP_INSERT, OP_ATTACH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (req.operation == OP_INSERT)
                        begin
                            at = cur_valid ? cursor_reg : '0;
                        end
                        else
                        begin
                            at = cur_valid ? CNT_BITS'(cursor_reg + 1'b1) : count_reg;
                        end
                        cmd.kind    = CMD_OPEN;
                        cmd.pos     = POS_BITS'(at);
                        count_next  = CNT_BITS'(count_reg + 1'b1);
                        cursor_next = at;
                    end
                end
                OP_REMOVE:
                begin
                    if (cur_valid)
                    begin
                        cmd.kind   = CMD_CLOSE;
                        cmd.pos    = POS_BITS'(cursor_reg);
                        count_next = CNT_BITS'(count_reg - 1'b1);
                    end
                    else
                    begin
                        status_next = ST_NOCUR;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = chain_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = chain_word[i+1];
        end

        csstore_cell #(
            .WORD_BITS (WORD_BITS),
            .CNT_BITS  (CNT_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .cursor     (cursor_reg),
            .word       (chain_word[i]),
            .sel_word   (chain_sel[i])
        );
    end

    always_comb
    begin
        sel_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            sel_or = sel_or | chain_sel[k];
        end
    end

    assign sel_wide = MAX_WORD'(sel_or);
    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            cursor_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_has_reg    <= cur_valid;
            out_value_reg  <= cur_valid ? sel_wide[OUT_WORD-1:0] : '0;
            out_count_reg  <= COUNT_OUT'(count_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.has_current   = out_has_reg;
    assign rsp.current_value = out_value_reg;
    assign rsp.item_count    = out_count_reg;
endmodule

/* rtl/core/csstore_checker.sv */
// Port-level checks of the cursor sequence store, bound to the top level.
`include "cursor_sequence_store_unit_defines.svh"

module csstore_checker #(
    parameter int DEPTH = 32
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [csstore_pkg::STATUS_BITS-1:0] rsp_status,
    input logic                               rsp_has_current,
    input logic [csstore_pkg::OUT_WORD-1:0]   rsp_current_value,
    input logic [csstore_pkg::COUNT_OUT-1:0]  rsp_item_count
);
    import csstore_pkg::*;

    `CSSU_ASSERT_NOW(a_no_current_zero, rsp_valid && !rsp_has_current, rsp_current_value == '0)
    `CSSU_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_item_count == COUNT_OUT'(DEPTH))
    `CSSU_ASSERT_NOW(a_nocur_flag, rsp_valid && rsp_status == ST_NOCUR, !rsp_has_current)
    `CSSU_ASSERT_NOW(a_count_bound, rsp_valid, DEPTH >= 64 || rsp_item_count <= COUNT_OUT'(DEPTH))
    `CSSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_current_value))
endmodule

bind cursor_sequence_store_unit csstore_checker #(
    .DEPTH (DEPTH)
) u_csstore_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_has_current   (rsp.has_current),
    .rsp_current_value (rsp.current_value),
    .rsp_item_count    (rsp.item_count)
);
